// ===== sv/pdu8_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pdu8_pkg
// Shared types, constants and helpers for the percent decoder with UTF-8
// check.
// ----------------------------------------------------------------------------
package pdu8_pkg;

    localparam int unsigned COUNT_W = 10;

    // Status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_ESCAPE   = 3'd1;
    localparam logic [2:0] ST_CONTROL  = 3'd2;
    localparam logic [2:0] ST_TOO_LONG = 3'd3;
    localparam logic [2:0] ST_UTF8     = 3'd4;

    // Escape phase codes
    localparam logic [1:0] PH_NONE = 2'd0;
    localparam logic [1:0] PH_HIGH = 2'd1;
    localparam logic [1:0] PH_LOW  = 2'd2;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DEL     = 8'h7F;

    localparam logic [7:0] CONT_LOW  = 8'h80;
    localparam logic [7:0] CONT_HIGH = 8'hBF;

    localparam logic [COUNT_W-1:0] MAX_BYTES_RESET = 10'd255;

    // Result of the decode stage for one item
    typedef struct packed {
        logic               emit;
        logic [7:0]         data;
        logic               done;
        logic [2:0]         err;
        logic [COUNT_W-1:0] count;
    } dec_res_t;

    // Returns {invalid, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'h10;
        if (c inside {[8'h30:8'h39]}) begin
            r = {1'b0, 4'(c - 8'h30)};
        end else if (c inside {[8'h61:8'h66]}) begin
            r = {1'b0, 4'(c - 8'h57)};
        end else if (c inside {[8'h41:8'h46]}) begin
            r = {1'b0, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== sv/pdu8_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pdu8_in_if / pdu8_out_if
// Valid/ready channels carrying raw bytes in and decoded results out.
// ----------------------------------------------------------------------------
interface pdu8_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] raw_byte;
    logic       last;
    logic       empty_component;

    modport source (output valid, output raw_byte, output last, output empty_component,
                    input ready);
    modport sink   (input valid, input raw_byte, input last, input empty_component,
                    output ready);
endinterface

interface pdu8_out_if;
    logic                         valid;
    logic                         ready;
    logic                         out_valid;
    logic [7:0]                   out_byte;
    logic                         done_res;
    logic [2:0]                   status;
    logic [pdu8_pkg::COUNT_W-1:0] decoded_count;

    modport source (output valid, output out_valid, output out_byte, output done_res,
                    output status, output decoded_count, input ready);
    modport sink   (input valid, input out_valid, input out_byte, input done_res,
                    input status, input decoded_count, output ready);
endinterface
`default_nettype wire

// ===== sv/percent_decode_utf8_check.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// percent_decode_utf8_check
// Percent decoder for one URI query component with control, length and
// strict UTF-8 checks; one result item for every raw byte item.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake         Carries
//  -------  ---  ----------------  -----------------------------------------
//  in_ch    in   valid/ready       raw_byte, last, empty_component
//  out_ch   out  valid/ready       out_valid, out_byte, done_res, status,
//                                  decoded_count
//  cfg      in   cfg_wr_en         cfg_wr_data -> max_bytes
//
//  One item a cycle while the result side keeps taking items; an accepted item
//  passes the input register, then the result register, before its result is valid.
//  The single decode step between the two registers sets the rate.
//  Reset clears the component state and loads max_bytes with 255.
//  A stalled result holds in the result register; the input register keeps
//  taking items as long as the result register can drain.
//
module percent_decode_utf8_check (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    pdu8_in_if.sink                           in_ch,
    pdu8_out_if.source                        out_ch,
    input  wire logic                         cfg_wr_en,
    input  wire logic [pdu8_pkg::COUNT_W-1:0] cfg_wr_data
);

    // Configuration register
    logic [pdu8_pkg::COUNT_W-1:0] max_bytes_reg;

    // Input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_raw_reg;
    logic       in_last_reg;
    logic       in_empty_reg;

    // Result register
    logic                         res_valid_reg, res_valid_next;
    logic                         res_out_valid_reg;
    logic [7:0]                   res_byte_reg;
    logic                         res_done_reg;
    logic [2:0]                   res_status_reg;
    logic [pdu8_pkg::COUNT_W-1:0] res_count_reg;

    logic               in_take;
    logic               res_free;
    logic               step;
    logic               utf8_bad;
    pdu8_pkg::dec_res_t dec;
    logic [2:0]         status_val;

    // Result register frees when empty or being taken this cycle
    assign res_free    = !res_valid_reg || out_ch.ready;
    assign step        = in_valid_reg && res_free;
    assign in_ch.ready = !in_valid_reg || res_free;
    assign in_take     = in_ch.valid && in_ch.ready;

    pdu8_decode u_decode (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (step),
        .raw_byte        (in_raw_reg),
        .last            (in_last_reg),
        .empty_component (in_empty_reg),
        .max_bytes       (max_bytes_reg),
        .res             (dec)
    );

    pdu8_utf8 u_utf8 (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .feed      (dec.emit),
        .data      (dec.data),
        .done      (dec.done),
        .bad_final (utf8_bad)
    );

    // First decode error wins; UTF-8 verdict only when decoding was clean
    always_comb
    begin
        if (dec.err != pdu8_pkg::ST_OK) begin
            status_val = dec.err;
        end else if (utf8_bad) begin
            status_val = pdu8_pkg::ST_UTF8;
        end else begin
            status_val = pdu8_pkg::ST_OK;
        end
    end

    always_comb
    begin
        if (in_take) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end

        if (step) begin
            res_valid_next = 1'b1;
        end else if (out_ch.ready) begin
            res_valid_next = 1'b0;
        end else begin
            res_valid_next = res_valid_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            max_bytes_reg <= pdu8_pkg::MAX_BYTES_RESET;
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                max_bytes_reg <= cfg_wr_data;
            end
            in_valid_reg  <= in_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload: capture the item, then the result
    always_ff @(posedge clk)
    begin
        if (in_take) begin
            in_raw_reg   <= in_ch.raw_byte;
            in_last_reg  <= in_ch.last;
            in_empty_reg <= in_ch.empty_component;
        end
        if (step) begin
            res_out_valid_reg <= dec.emit;
            res_byte_reg      <= dec.emit ? dec.data : 8'd0;
            res_done_reg      <= dec.done;
            res_status_reg    <= dec.done ? status_val : pdu8_pkg::ST_OK;
            res_count_reg     <= dec.done ? dec.count : '0;
        end
    end

    assign out_ch.valid         = res_valid_reg;
    assign out_ch.out_valid     = res_out_valid_reg;
    assign out_ch.out_byte      = res_byte_reg;
    assign out_ch.done_res      = res_done_reg;
    assign out_ch.status        = res_status_reg;
    assign out_ch.decoded_count = res_count_reg;

endmodule
`default_nettype wire

// ===== sv/pdu8_decode.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pdu8_decode
// Percent-escape decoder with control-byte and length checks.
// ----------------------------------------------------------------------------
module pdu8_decode (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         step,
    input  wire logic [7:0]                   raw_byte,
    input  wire logic                         last,
    input  wire logic                         empty_component,
    input  wire logic [pdu8_pkg::COUNT_W-1:0] max_bytes,
    output pdu8_pkg::dec_res_t                res
);

    logic [1:0]                   phase_reg, phase_next;
    logic [3:0]                   nibble_reg, nibble_next;
    logic [pdu8_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [2:0]                   err_reg, err_next;

    logic [4:0] hex;
    logic [7:0] c;
    logic       have_c;
    logic [1:0] ph_upd;
    logic [2:0] err_upd;
    logic [pdu8_pkg::COUNT_W-1:0] cnt_upd;

    always_comb
    begin
        hex     = pdu8_pkg::hex_digit(raw_byte);
        ph_upd  = phase_reg;
        nibble_next = nibble_reg;
        cnt_upd = count_reg;
        err_upd = err_reg;
        c       = raw_byte;
        have_c  = 1'b0;
        res.emit = 1'b0;

        if (!empty_component && err_reg == pdu8_pkg::ST_OK) begin
            if (phase_reg == pdu8_pkg::PH_NONE) begin
                if (raw_byte == pdu8_pkg::CH_PERCENT) begin
                    ph_upd = pdu8_pkg::PH_HIGH;
                end else begin
                    have_c = 1'b1;
                end
            end else if (hex[4]) begin
                err_upd = pdu8_pkg::ST_ESCAPE;
                ph_upd  = pdu8_pkg::PH_NONE;
            end else if (phase_reg == pdu8_pkg::PH_HIGH) begin
                nibble_next = hex[3:0];
                ph_upd      = pdu8_pkg::PH_LOW;
            end else begin
                c      = {nibble_reg, hex[3:0]};
                ph_upd = pdu8_pkg::PH_NONE;
                have_c = 1'b1;
            end

            if (have_c) begin
                if (c < pdu8_pkg::CH_SPACE || c == pdu8_pkg::CH_DEL) begin
                    err_upd = pdu8_pkg::ST_CONTROL;
                end else if (count_reg >= max_bytes) begin
                    err_upd = pdu8_pkg::ST_TOO_LONG;
                end else begin
                    cnt_upd  = count_reg + 1'b1;
                    res.emit = 1'b1;
                end
            end
        end

        res.data  = c;
        res.done  = empty_component | last;
        res.count = cnt_upd;
        // An escape still open at the end is cut short
        if (err_upd == pdu8_pkg::ST_OK && ph_upd != pdu8_pkg::PH_NONE) begin
            res.err = pdu8_pkg::ST_ESCAPE;
        end else begin
            res.err = err_upd;
        end

        if (res.done) begin
            phase_next  = pdu8_pkg::PH_NONE;
            nibble_next = 4'd0;
            count_next  = '0;
            err_next    = pdu8_pkg::ST_OK;
        end else begin
            phase_next  = ph_upd;
            count_next  = cnt_upd;
            err_next    = err_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg  <= pdu8_pkg::PH_NONE;
            nibble_reg <= 4'd0;
            count_reg  <= '0;
            err_reg    <= pdu8_pkg::ST_OK;
        end else if (step) begin
            phase_reg  <= phase_next;
            nibble_reg <= nibble_next;
            count_reg  <= count_next;
            err_reg    <= err_next;
        end
    end

endmodule
`default_nettype wire

// ===== sv/pdu8_utf8.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pdu8_utf8
// Strict UTF-8 tracker over the stream of decoded bytes.
// ----------------------------------------------------------------------------
module pdu8_utf8 (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic       feed,
    input  wire logic [7:0] data,
    input  wire logic       done,
    output logic            bad_final
);

    logic [1:0] rem_reg, rem_next;
    logic [7:0] low_reg, low_next;
    logic [7:0] high_reg, high_next;
    logic       bad_reg, bad_next;

    logic [1:0] rem_upd;
    logic [7:0] low_upd, high_upd;
    logic       bad_upd;

    always_comb
    begin
        rem_upd  = rem_reg;
        low_upd  = low_reg;
        high_upd = high_reg;
        bad_upd  = bad_reg;

        if (feed && !bad_reg) begin
            if (rem_reg != 2'd0) begin
                // Continuation byte: check against the allowed window
                if (data < low_reg || data > high_reg) begin
                    bad_upd = 1'b1;
                    rem_upd = 2'd0;
                end else begin
                    rem_upd = rem_reg - 2'd1;
                end
                low_upd  = pdu8_pkg::CONT_LOW;
                high_upd = pdu8_pkg::CONT_HIGH;
            end else if (data >= 8'h80) begin
                low_upd  = pdu8_pkg::CONT_LOW;
                high_upd = pdu8_pkg::CONT_HIGH;
                if (data inside {[8'hC2:8'hDF]}) begin
                    rem_upd = 2'd1;
                end else if (data == 8'hE0) begin
                    rem_upd = 2'd2;
                    low_upd = 8'hA0;
                end else if (data == 8'hED) begin
                    rem_upd  = 2'd2;
                    high_upd = 8'h9F;
                end else if (data inside {[8'hE1:8'hEF]}) begin
                    rem_upd = 2'd2;
                end else if (data == 8'hF0) begin
                    rem_upd = 2'd3;
                    low_upd = 8'h90;
                end else if (data inside {[8'hF1:8'hF3]}) begin
                    rem_upd = 2'd3;
                end else if (data == 8'hF4) begin
                    rem_upd  = 2'd3;
                    high_upd = 8'h8F;
                end else begin
                    bad_upd  = 1'b1;
                    low_upd  = low_reg;
                    high_upd = high_reg;
                end
            end
        end

        bad_final = bad_upd | (rem_upd != 2'd0);

        if (done) begin
            rem_next  = 2'd0;
            low_next  = pdu8_pkg::CONT_LOW;
            high_next = pdu8_pkg::CONT_HIGH;
            bad_next  = 1'b0;
        end else begin
            rem_next  = rem_upd;
            low_next  = low_upd;
            high_next = high_upd;
            bad_next  = bad_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rem_reg  <= 2'd0;
            low_reg  <= pdu8_pkg::CONT_LOW;
            high_reg <= pdu8_pkg::CONT_HIGH;
            bad_reg  <= 1'b0;
        end else if (step) begin
            rem_reg  <= rem_next;
            low_reg  <= low_next;
            high_reg <= high_next;
            bad_reg  <= bad_next;
        end
    end

endmodule
`default_nettype wire

// ===== sv/pdu8_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pdu8_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module pdu8_checker (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         out_ch_valid,
    input  wire logic                         out_ch_ready,
    input  wire logic                         out_valid,
    input  wire logic [7:0]                   out_byte,
    input  wire logic                         done_res,
    input  wire logic [2:0]                   status,
    input  wire logic [pdu8_pkg::COUNT_W-1:0] decoded_count
);

    // A stalled result holds its payload
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch_valid && !out_ch_ready |=> out_ch_valid
            && $stable({out_valid, out_byte, done_res, status, decoded_count}))
        else $error("result changed while stalled");

    // Status and count only show on the final item
    a_done_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch_valid && !done_res |-> status == pdu8_pkg::ST_OK && decoded_count == '0)
        else $error("status or count outside done");

    // No byte shown without a decoded byte
    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch_valid && !out_valid |-> out_byte == 8'd0)
        else $error("out_byte set without out_valid");

    // Status stays within its codes
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch_valid |-> status <= pdu8_pkg::ST_UTF8)
        else $error("status out of range");

endmodule

bind percent_decode_utf8_check pdu8_checker u_pdu8_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_ch_valid  (out_ch.valid),
    .out_ch_ready  (out_ch.ready),
    .out_valid     (out_ch.out_valid),
    .out_byte      (out_ch.out_byte),
    .done_res      (out_ch.done_res),
    .status        (out_ch.status),
    .decoded_count (out_ch.decoded_count)
);
`default_nettype wire

// ===== bench/decode_result_checker.sv =====
// ----------------------------------------------------------------------------
// decode_result_checker
// Watches both channels of the percent decoder. Each raw byte item taken by
// the block is run through a local model of the decoder and its expected
// result queued; each result item the block hands out is compared field by
// field with the oldest queued expectation.
// ----------------------------------------------------------------------------
module decode_result_checker
    import pdu8_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    pdu8_in_if                      in_ch,
    pdu8_out_if                     out_ch,
    input  wire logic               cfg_wr_en,
    input  wire logic [COUNT_W-1:0] cfg_wr_data,
    output int unsigned             mismatches,
    output int unsigned             awaited,
    output int unsigned             results_seen,
    output int unsigned             components_seen,
    output int unsigned             faults_seen,
    output int unsigned             bytes_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned PRINT_CAP = 50;

    // Local copy of the decoder state
    logic [COUNT_W-1:0] limit_bytes;
    logic [1:0]         esc_phase;
    logic [3:0]         esc_high;
    logic [COUNT_W-1:0] kept_bytes;
    logic [1:0]         cont_due;
    logic [7:0]         cont_min;
    logic [7:0]         cont_max;
    logic [2:0]         first_err;
    logic               seq_bad;

    dec_res_t    decoded_q[$];
    int unsigned n_err;
    int unsigned n_res;
    int unsigned n_done;
    int unsigned n_fault;
    int unsigned n_emit;

    task automatic clear_component();
        esc_phase  = PH_NONE;
        esc_high   = 4'd0;
        kept_bytes = '0;
        cont_due   = 2'd0;
        cont_min   = CONT_LOW;
        cont_max   = CONT_HIGH;
        first_err  = ST_OK;
        seq_bad    = 1'b0;
    endtask

    // Bit 4 set: not a hex digit
    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h10;
        if (c >= "0" && c <= "9") v = c - "0";
        else if (c >= "a" && c <= "f") v = c - "a" + 8'd10;
        else if (c >= "A" && c <= "F") v = c - "A" + 8'd10;
        return v[4:0];
    endfunction

    task automatic open_seq(input logic [1:0] n, input logic [7:0] lo, input logic [7:0] hi);
        cont_due = n;
        cont_min = lo;
        cont_max = hi;
    endtask

    task automatic track_utf8(input logic [7:0] c);
        if (seq_bad) return;
        if (cont_due != 2'd0) begin
            if (c < cont_min || c > cont_max) begin
                seq_bad  = 1'b1;
                cont_due = 2'd0;
            end else begin
                cont_due = cont_due - 2'd1;
            end
            cont_min = CONT_LOW;
            cont_max = CONT_HIGH;
        end else if (c >= 8'h80) begin
            if (c >= 8'hC2 && c <= 8'hDF) open_seq(2'd1, CONT_LOW, CONT_HIGH);
            else if (c == 8'hE0) open_seq(2'd2, 8'hA0, CONT_HIGH);
            else if (c == 8'hED) open_seq(2'd2, CONT_LOW, 8'h9F);
            else if (c >= 8'hE1 && c <= 8'hEF) open_seq(2'd2, CONT_LOW, CONT_HIGH);
            else if (c == 8'hF0) open_seq(2'd3, 8'h90, CONT_HIGH);
            else if (c >= 8'hF1 && c <= 8'hF3) open_seq(2'd3, CONT_LOW, CONT_HIGH);
            else if (c == 8'hF4) open_seq(2'd3, CONT_LOW, 8'h8F);
            else seq_bad = 1'b1;
        end
    endtask

    // Advance the model by one raw item and work out its result
    task automatic decode_raw_item(input logic [7:0] raw, input logic fin, input logic skip,
                                   output dec_res_t r);
        logic [7:0] c;
        logic [4:0] nib;
        logic       have;
        r    = '0;
        c    = 8'h00;
        have = 1'b0;
        if (!skip && first_err == ST_OK) begin
            if (esc_phase == PH_NONE) begin
                if (raw == CH_PERCENT) esc_phase = PH_HIGH;
                else begin
                    c    = raw;
                    have = 1'b1;
                end
            end else begin
                nib = nibble_of(raw);
                if (nib[4]) begin
                    first_err = ST_ESCAPE;
                    esc_phase = PH_NONE;
                end else if (esc_phase == PH_HIGH) begin
                    esc_high  = nib[3:0];
                    esc_phase = PH_LOW;
                end else begin
                    c         = {esc_high, nib[3:0]};
                    esc_phase = PH_NONE;
                    have      = 1'b1;
                end
            end
            if (have) begin
                if (c < CH_SPACE || c == CH_DEL) first_err = ST_CONTROL;
                else if (kept_bytes >= limit_bytes) first_err = ST_TOO_LONG;
                else begin
                    kept_bytes = kept_bytes + 1'b1;
                    track_utf8(c);
                    r.emit = 1'b1;
                    r.data = c;
                end
            end
        end
        if (skip || fin) begin
            if (first_err == ST_OK && esc_phase != PH_NONE) first_err = ST_ESCAPE;
            r.done = 1'b1;
            if (first_err != ST_OK) r.err = first_err;
            else if (seq_bad || cont_due != 2'd0) r.err = ST_UTF8;
            else r.err = ST_OK;
            r.count = kept_bytes;
            clear_component();
        end
    endtask

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        n_err++;
        if (n_err <= PRINT_CAP)
            $display("%0t ns result %0d: %s is %0h, %0h expected", $time, n_res, what, got, want);
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        dec_res_t want;
        if (!rst_n) begin
            limit_bytes = MAX_BYTES_RESET;
            clear_component();
            decoded_q.delete();
            n_err   = 0;
            n_res   = 0;
            n_done  = 0;
            n_fault = 0;
            n_emit  = 0;
        end else begin
            if (cfg_wr_en) limit_bytes = cfg_wr_data;
            if (in_ch.valid && in_ch.ready) begin
                decode_raw_item(in_ch.raw_byte, in_ch.last, in_ch.empty_component, want);
                decoded_q.push_back(want);
            end
            if (out_ch.valid && out_ch.ready) begin
                n_res++;
                if (decoded_q.size() == 0) begin
                    report_mismatch("unexpected result", 16'(out_ch.done_res), 16'h0);
                end else begin
                    want = decoded_q.pop_front();
                    if (out_ch.out_valid !== want.emit)
                        report_mismatch("out_valid", 16'(out_ch.out_valid), 16'(want.emit));
                    if (out_ch.out_byte !== want.data)
                        report_mismatch("out_byte", 16'(out_ch.out_byte), 16'(want.data));
                    if (out_ch.done_res !== want.done)
                        report_mismatch("done_res", 16'(out_ch.done_res), 16'(want.done));
                    if (out_ch.status !== want.err)
                        report_mismatch("status", 16'(out_ch.status), 16'(want.err));
                    if (out_ch.decoded_count !== want.count)
                        report_mismatch("decoded_count", 16'(out_ch.decoded_count),
                                        16'(want.count));
                    if (want.emit) n_emit++;
                    if (want.done) begin
                        n_done++;
                        if (want.err != ST_OK) n_fault++;
                    end
                end
            end
        end
        mismatches      <= n_err;
        awaited         <= decoded_q.size();
        results_seen    <= n_res;
        components_seen <= n_done;
        faults_seen     <= n_fault;
        bytes_seen      <= n_emit;
    end

endmodule

// ===== bench/percent_decode_utf8_check_tb.sv =====
// ----------------------------------------------------------------------------
// percent_decode_utf8_check_tb
// Drives raw query-component bytes into the percent decoder with random
// gaps and output stalls: a directed opening over escapes, control bytes,
// UTF-8 corner cases and the length limit, then random components that are
// mostly well-formed encoded UTF-8 with injected faults and noise, across
// several length limits. Results are checked by decode_result_checker.
// ----------------------------------------------------------------------------
module percent_decode_utf8_check_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pdu8_pkg::*;

    localparam int unsigned LIMIT_CYCLES = 400000;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned PHASE_ITEMS  = 75;
    localparam int unsigned DRAIN_CYCLES = 6;
    localparam int unsigned LONG_BYTES   = 513;
    localparam logic [COUNT_W-1:0] LONG_LIMIT = 10'd511;

    typedef struct packed {
        logic [7:0] raw;
        logic       fin;
        logic       skip;
    } raw_item_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic [COUNT_W-1:0] cfg_wr_data;

    // Stimulus knobs shared by the two driving processes
    bit src_calm = 1'b0;
    bit snk_calm = 1'b0;
    bit hold_req = 1'b0;

    int unsigned sent       = 0;
    int unsigned cfg_writes = 0;
    int unsigned cycles     = 0;

    int unsigned mismatches;
    int unsigned awaited;
    int unsigned results_seen;
    int unsigned components_seen;
    int unsigned faults_seen;
    int unsigned bytes_seen;

    raw_item_t comp_q[$];

    pdu8_in_if  in_ch();
    pdu8_out_if out_ch();

    percent_decode_utf8_check i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    decode_result_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_ch           (in_ch),
        .out_ch          (out_ch),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .mismatches      (mismatches),
        .awaited         (awaited),
        .results_seen    (results_seen),
        .components_seen (components_seen),
        .faults_seen     (faults_seen),
        .bytes_seen      (bytes_seen)
    );

    always #1ns clk = ~clk;

    // Watchdog: stop a hung run at a generous cycle count
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES)
        begin
            $display("Timed out after %0d cycles, %0d results still due", cycles, awaited);
            $display("percent_decode_utf8_check_tb: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Item helpers
    // ------------------------------------------------------------------------

    // Hex digit as ASCII, letters in a random case
    function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
        if (nib < 4'd10) return 8'h30 + 8'(nib);
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
    endfunction

    task automatic add_raw(input logic [7:0] b);
        raw_item_t it;
        it.raw  = b;
        it.fin  = 1'b0;
        it.skip = 1'b0;
        comp_q.push_back(it);
    endtask

    // Queue one decoded byte, either literally or as a %HH escape.
    // A '%' can only travel escaped.
    task automatic add_byte(input logic [7:0] b);
        if (b == CH_PERCENT || $urandom_range(0, 1))
        begin
            add_raw(CH_PERCENT);
            add_raw(hex_ascii(b[7:4]));
            add_raw(hex_ascii(b[3:0]));
        end
        else
        begin
            add_raw(b);
        end
    endtask

    task automatic add_cont(input logic [7:0] lo, input logic [7:0] hi);
        add_byte(8'($urandom_range(lo, hi)));
    endtask

    // One well-formed character: printable ASCII or a 2, 3 or 4 byte sequence
    // that respects the narrowed ranges after E0, ED, F0 and F4.
    task automatic add_char();
        int         cls;
        logic [7:0] lead;
        cls = $urandom_range(0, 9);
        if (cls < 4)
        begin
            add_byte(8'($urandom_range(CH_SPACE, 8'h7E)));
        end
        else if (cls < 6)
        begin
            add_byte(8'($urandom_range(8'hC2, 8'hDF)));
            add_cont(CONT_LOW, CONT_HIGH);
        end
        else if (cls < 8)
        begin
            lead = 8'($urandom_range(8'hE0, 8'hEF));
            add_byte(lead);
            if (lead == 8'hE0) add_cont(8'hA0, CONT_HIGH);
            else if (lead == 8'hED) add_cont(CONT_LOW, 8'h9F);
            else add_cont(CONT_LOW, CONT_HIGH);
            add_cont(CONT_LOW, CONT_HIGH);
        end
        else
        begin
            lead = 8'($urandom_range(8'hF0, 8'hF4));
            add_byte(lead);
            if (lead == 8'hF0) add_cont(8'h90, CONT_HIGH);
            else if (lead == 8'hF4) add_cont(CONT_LOW, 8'h8F);
            else add_cont(CONT_LOW, CONT_HIGH);
            add_cont(CONT_LOW, CONT_HIGH);
            add_cont(CONT_LOW, CONT_HIGH);
        end
    endtask

    // Inject one fault; kind picks UTF-8, escape or control faults
    task automatic add_fault(input int kind);
        int         f;
        logic [7:0] b;
        f = $urandom_range(0, 5);
        if (kind < 75)
        begin
            case (f)
                // stray continuation byte
                0: add_cont(CONT_LOW, CONT_HIGH);
                // lead bytes that never start a sequence
                1: add_byte($urandom_range(0, 1) ? 8'($urandom_range(8'hC0, 8'hC1))
                                                 : 8'($urandom_range(8'hF5, 8'hFF)));
                // overlong three-byte form
                2: begin
                    add_byte(8'hE0);
                    add_cont(CONT_LOW, 8'h9F);
                    add_cont(CONT_LOW, CONT_HIGH);
                end
                // surrogate half
                3: begin
                    add_byte(8'hED);
                    add_cont(8'hA0, CONT_HIGH);
                    add_cont(CONT_LOW, CONT_HIGH);
                end
                // overlong four-byte form, or beyond U+10FFFF
                4: begin
                    if ($urandom_range(0, 1))
                    begin
                        add_byte(8'hF0);
                        add_cont(CONT_LOW, 8'h8F);
                    end
                    else
                    begin
                        add_byte(8'hF4);
                        add_cont(8'h90, CONT_HIGH);
                    end
                end
                // lead with its tail missing
                default: add_byte(8'($urandom_range(8'hC2, 8'hF4)));
            endcase
        end
        else if (kind < 85)
        begin
            // Non-hex byte: flipping bit 6 moves any hex digit off the digit set
            b = 8'($urandom);
            if ((b >= "0" && b <= "9") || (b >= "A" && b <= "F") || (b >= "a" && b <= "f"))
                b = b ^ 8'h40;
            add_raw(CH_PERCENT);
            if (f >= 3) add_raw(hex_ascii(4'($urandom)));
            // odd f breaks the escape; even f leaves it open for what follows
            if (f[0]) add_raw(b);
        end
        else
        begin
            add_byte($urandom_range(0, 3) == 0 ? CH_DEL : 8'($urandom_range(0, 8'h1F)));
        end
    endtask

    // Build one component in comp_q: mostly well-formed text, some with a
    // single injected fault, a few pure noise. End it on its final byte or
    // with a separate empty-component item.
    task automatic make_component();
        int        kind;
        int        n;
        int        pos;
        raw_item_t it;
        comp_q.delete();
        kind = $urandom_range(0, 99);
        n    = $urandom_range(0, 7);
        if (kind >= 93)
        begin
            repeat ($urandom_range(1, 8)) add_raw(8'($urandom));
        end
        else
        begin
            pos = $urandom_range(0, n);
            for (int k = 0; k <= n; k++)
            begin
                if (k == pos && kind >= 60) add_fault(kind);
                if (k < n) add_char();
            end
        end
        if (comp_q.size() == 0 || $urandom_range(0, 9) < 2)
        begin
            it.raw  = 8'($urandom);
            it.fin  = 1'($urandom);
            it.skip = 1'b1;
        end
        else
        begin
            it     = comp_q.pop_back();
            it.fin = 1'b1;
        end
        comp_q.push_back(it);
    endtask

    // ------------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------------

    // Offer one item after a random gap and hold it until taken.
    // Valid stays high into the next item when that one has no gap.
    task automatic drive_item(input logic [7:0] raw, input logic fin, input logic skip);
        int gap;
        gap = src_calm ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.raw_byte        <= raw;
        in_ch.last            <= fin;
        in_ch.empty_component <= skip;
        in_ch.valid           <= 1'b1;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        sent++;
    endtask

    task automatic send_component();
        foreach (comp_q[k]) drive_item(comp_q[k].raw, comp_q[k].fin, comp_q[k].skip);
    endtask

    // Drop valid, wait for every outstanding result, then wait out the drain time
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (awaited != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write the length limit with the block idle
    task automatic set_limit(input logic [COUNT_W-1:0] v);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        cfg_writes++;
    endtask

    // Result side: random stall before each item, plus one long hold-off
    // when the stimulus asks, counted here so the sender keeps pushing.
    initial
    begin : result_side
        int gap;
        out_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            gap = snk_calm ? 0 : $urandom_range(0, 19);
            if (gap > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid) @(posedge clk);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and verdict
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int                 ph;
        int unsigned        phase_start;
        bit                 hold_asked;
        logic [COUNT_W-1:0] lim;
        logic [7:0]         b;
        raw_item_t          it;

        hold_asked = 1'b0;

        // Known values on every input from time zero
        rst_n                 <= 1'b0;
        cfg_wr_en             <= 1'b0;
        cfg_wr_data           <= '0;
        in_ch.valid           <= 1'b0;
        in_ch.raw_byte        <= 8'h00;
        in_ch.last            <= 1'b0;
        in_ch.empty_component <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- Directed opening, limit at its reset value ---
        // plain character
        drive_item("A", 1'b1, 1'b0);
        // escapes with lower and upper case hex
        drive_item(CH_PERCENT, 1'b0, 1'b0);
        drive_item("7", 1'b0, 1'b0);
        drive_item("e", 1'b0, 1'b0);
        drive_item(CH_PERCENT, 1'b0, 1'b0);
        drive_item("7", 1'b0, 1'b0);
        drive_item("E", 1'b1, 1'b0);
        // escape cut short by the end of the component
        drive_item(CH_PERCENT, 1'b0, 1'b0);
        drive_item("4", 1'b1, 1'b0);
        // bad hex digit; the byte after it is ignored
        drive_item(CH_PERCENT, 1'b0, 1'b0);
        drive_item("G", 1'b0, 1'b0);
        drive_item("x", 1'b1, 1'b0);
        // empty component with a junk byte alongside
        drive_item(8'hFF, 1'b0, 1'b1);
        // control bytes at both ends of the banned set
        drive_item(CH_DEL, 1'b1, 1'b0);
        drive_item(8'h00, 1'b1, 1'b0);
        // good two-byte sequence
        drive_item(8'hC3, 1'b0, 1'b0);
        drive_item(8'hA9, 1'b1, 1'b0);
        // overlong three-byte lead
        drive_item(8'hE0, 1'b0, 1'b0);
        drive_item(8'h80, 1'b1, 1'b0);
        // sequence left open at the end
        drive_item(8'hF4, 1'b1, 1'b0);
        // empty item ends a component already under way
        drive_item("b", 1'b0, 1'b0);
        drive_item(8'h00, 1'b0, 1'b1);
        // last and empty together; raw byte must be ignored
        drive_item(CH_PERCENT, 1'b1, 1'b1);
        // zero limit: first decoded byte is already too long
        set_limit('0);
        drive_item("a", 1'b1, 1'b0);
        // limit met exactly, then exceeded
        set_limit(10'd2);
        drive_item("a", 1'b0, 1'b0);
        drive_item("b", 1'b0, 1'b0);
        drive_item("c", 1'b1, 1'b0);

        // --- Random phases, one limit setting each ---
        for (ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0:       lim = 10'd1023;
                1:       lim = 10'd0;
                2:       lim = 10'd6;
                3:       lim = 10'($urandom_range(3, 30));
                4:       lim = 10'd1;
                5:       lim = 10'($urandom_range(0, 1023));
                6:       lim = 10'd2;
                default: lim = MAX_BYTES_RESET;
            endcase
            set_limit(lim);
            // one phase runs flat out on both sides; others may by chance
            src_calm    = (ph == 4) || ($urandom_range(0, 3) == 0);
            snk_calm    = (ph == 4) || ($urandom_range(0, 3) == 0);
            phase_start = sent;
            while (sent - phase_start < PHASE_ITEMS)
            begin
                // halfway through phase 2, stall the result side for a long
                // stretch while items keep coming, so the input backs up
                if (ph == 2 && !hold_asked && sent - phase_start > PHASE_ITEMS / 2)
                begin
                    hold_req   = 1'b1;
                    hold_asked = 1'b1;
                end
                make_component();
                send_component();
            end
        end

        // --- A high limit reached and exceeded by one long component ---
        set_limit(LONG_LIMIT);
        src_calm = 1'b1;
        snk_calm = 1'b1;
        comp_q.delete();
        repeat (LONG_BYTES)
        begin
            b = 8'($urandom_range(CH_SPACE, 8'h7E));
            if (b == CH_PERCENT) b = "+";
            add_raw(b);
        end
        it     = comp_q.pop_back();
        it.fin = 1'b1;
        comp_q.push_back(it);
        send_component();

        wait_drained();

        $display("Sent %0d raw bytes in %0d components under %0d limit writes, 0 to 1023.",
                 sent, components_seen, cfg_writes);
        $display("Checked %0d results: %0d bytes decoded, %0d components ended in error.",
                 results_seen, bytes_seen, faults_seen);
        if (mismatches == 0 && awaited == 0)
            $display("percent_decode_utf8_check_tb: PASS");
        else
            $display("percent_decode_utf8_check_tb: FAIL");
        $finish;
    end

endmodule
